// ===== hdl/bda_pkg.sv =====
// Shared constants and control types for the binary to decimal ASCII converter.
// Used by bda_ctrl, bda_datapath and binary_to_decimal_ascii_top.
`default_nettype none

package bda_pkg;

  // Operand and BCD sizes
  localparam int BIN_W         = 64;
  localparam int NUM_DIGITS    = 20;
  localparam int IDX_W         = $clog2(NUM_DIGITS);
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS    = BIN_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(CONV_STEPS);

  // Character codes
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture operand, clear BCD
    logic conv;   // one shift-add-3 step of BITS_PER_STEP bits
    logic count;  // find the leading significant digit
    logic emit;   // load the next character into the output register
  } bda_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sign_pend;  // a '-' still has to go out
    logic idx_zero;   // digit pointer at the least significant digit
  } bda_stat_t;

endpackage

`default_nettype wire

// ===== hdl/bda_ctrl.sv =====
// Sequencer for the converter: accept, convert, count digits, emit characters.
// Depends on bda_pkg for command and status types.
`default_nettype none

module bda_ctrl
  import bda_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire bda_stat_t stat,
  output bda_cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_COUNT,
    ST_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_space;

  assign out_space = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv = 1'b1;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(CONV_STEPS - 1)) begin
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        cmd.count = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_space) begin
          cmd.emit = 1'b1;
          if (!stat.sign_pend && stat.idx_zero) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // Output word valid: set on emit, cleared when taken
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  // An accepted word always starts conversion at step zero
  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_CONV && step_r == '0))
    else $error("conversion did not start after accept");

  // Conversion moves on to the digit count after step CONV_STEPS - 1
  a_conv_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV && step_r == STEP_W'(CONV_STEPS - 1)) |=> (state_r == ST_COUNT))
    else $error("conversion length wrong");

  // A minus sign is never the final character
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && stat.sign_pend) |=> (state_r == ST_EMIT))
    else $error("left emit after the sign");

  // Emitting only happens with room in the output register
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (state_r == ST_EMIT && out_space))
    else $error("emit without output space");
`endif

endmodule

`default_nettype wire

// ===== hdl/bda_datapath.sv =====
// Datapath: operand negate, shift-add-3 BCD conversion, digit pointer, output word.
// Depends on bda_pkg for sizes, character codes and command/status types.
`default_nettype none

module bda_datapath
  import bda_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [BIN_W-1:0] in_value,
  input  wire logic             in_signed_mode,
  input  wire bda_cmd_t         cmd,
  output bda_stat_t             stat,
  output logic [7:0]            out_char_code,
  output logic                  out_last_char
);

  logic [BIN_W-1:0]                bin_r, bin_nxt;
  logic [NUM_DIGITS-1:0][3:0]      bcd_r, bcd_nxt;
  logic                            sign_r;
  logic [IDX_W-1:0]                idx_r, top_idx;
  logic [7:0]                      char_r;
  logic                            last_r;
  logic                            neg;

  assign neg = in_signed_mode && in_value[BIN_W-1];

  // BITS_PER_STEP rounds of add-3 then shift per cycle
  always_comb begin
    bcd_nxt = bcd_r;
    bin_nxt = bin_r;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (bcd_nxt[d] >= 4'd5) begin
          bcd_nxt[d] = bcd_nxt[d] + 4'd3;
        end
      end
      {bcd_nxt, bin_nxt} = {bcd_nxt, bin_nxt} << 1;
    end
  end

  // Highest nonzero digit, zero when the whole number is zero
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_r[d] != 4'd0) begin
        top_idx = IDX_W'(d);
      end
    end
  end

  // Sign flag is control state and gets a reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sign_r <= 1'b0;
    end else if (cmd.load) begin
      sign_r <= neg;
    end else if (cmd.emit && sign_r) begin
      sign_r <= 1'b0;
    end
  end

  // Working registers and output word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin_r <= neg ? (~in_value + BIN_W'(1)) : in_value;
      bcd_r <= '0;
    end else if (cmd.conv) begin
      bin_r <= bin_nxt;
      bcd_r <= bcd_nxt;
    end
    if (cmd.count) begin
      idx_r <= top_idx;
    end else if (cmd.emit && !sign_r && idx_r != '0) begin
      idx_r <= idx_r - IDX_W'(1);
    end
    if (cmd.emit) begin
      if (sign_r) begin
        char_r <= CHAR_MINUS;
        last_r <= 1'b0;
      end else begin
        char_r <= CHAR_ZERO + {4'b0000, bcd_r[idx_r]};
        last_r <= (idx_r == '0);
      end
    end
  end

  assign stat.sign_pend = sign_r;
  assign stat.idx_zero  = (idx_r == '0);
  assign out_char_code  = char_r;
  assign out_last_char  = last_r;

endmodule

`default_nettype wire

// ===== hdl/binary_to_decimal_ascii_top.sv =====
// Top level of the 64-bit binary to decimal ASCII converter.
// Instantiates bda_ctrl and bda_datapath; depends on bda_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one word: in_value (64 bits) and
//   in_signed_mode (1 = two's complement). Output channel (out_valid/out_ready)
//   gives one ASCII character per word, most significant first, with
//   out_last_char high on the final one. A negative signed value gives '-'
//   first; zero gives a single '0'; the most negative value gives
//   "-9223372036854775808".
// Timing:
//   After accept, the word is converted by shift-add-3, four bits per cycle,
//   then the leading digit is located before the first character is valid.
//   Characters then leave one per cycle while out_ready is high. in_ready
//   stays low from accept until the final character is loaded into the output
//   register, so no new number is taken while one is converted or emitted.
//   in_ready returns while the final character may still wait in the output
//   register, so the next number's conversion overlaps that wait.
// Reset: rst_n (synchronous, active low) returns to idle and drops out_valid.
// Stall: with out_valid high and out_ready low the output word holds and emission pauses.
`default_nettype none

module binary_to_decimal_ascii_top
  import bda_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [BIN_W-1:0] in_value,
  input  wire logic             in_signed_mode,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            out_char_code,
  output logic                  out_last_char
);

  bda_cmd_t  cmd;
  bda_stat_t stat;

  bda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bda_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_value),
    .in_signed_mode (in_signed_mode),
    .cmd            (cmd),
    .stat           (stat),
    .out_char_code  (out_char_code),
    .out_last_char  (out_last_char)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_binary_to_decimal_ascii_top.sv =====
// Self-checking testbench for binary_to_decimal_ascii_top: feeds 64-bit words
// and checks every ASCII character against typed-in text or an in-bench decimal formatter.
// Depends on bda_pkg and the converter RTL only.
`default_nettype none

module tb_binary_to_decimal_ascii_top;
  import bda_pkg::*;

  localparam logic MODE_UNSIGNED = 1'b0;
  localparam logic MODE_SIGNED   = 1'b1;
  localparam int   N_DIRECTED    = 21;
  localparam int   N_RANDOM      = 340;
  localparam int   MAX_WAIT      = 18;
  localparam int   DRAIN_CYCLES  = 60;
  localparam int   STALL_LIMIT   = 4000;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } ascii_char_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [BIN_W-1:0] in_value;
  logic             in_signed_mode;
  logic             out_valid;
  logic             out_ready;
  logic [7:0]       out_char_code;
  logic             out_last_char;

  // characters still owed by the block, oldest first
  ascii_char_t      pending_chars[$];
  logic [63:0]      pow10[0:19];
  logic             steady;
  int               mismatches;
  int               words_sent;
  int               negatives_sent;
  int               full_width_words;
  int               chars_checked;
  int               idle_cycles;

  binary_to_decimal_ascii_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_signed_mode (in_signed_mode),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char_code  (out_char_code),
    .out_last_char  (out_last_char)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // wait before the next word / character; none at all in steady phases
  function automatic int draw_wait();
    if (steady) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // decimal formatter: sign, then digits most significant first
  function automatic void predict_text(input logic [63:0] word, input logic as_signed);
    logic [63:0] mag;
    logic [3:0]  digits[0:19];
    logic        neg;
    int          n;
    int          k;
    ascii_char_t c;
    neg = (as_signed == MODE_SIGNED) && word[63];
    mag = neg ? (~word + 64'd1) : word;
    n = 0;
    while (n == 0 || (mag != 64'd0 && n < NUM_DIGITS)) begin
      digits[n] = 4'(mag % 64'd10);
      mag = mag / 64'd10;
      n++;
    end
    if (neg) begin
      c.code = CHAR_MINUS;
      c.last = 1'b0;
      pending_chars.push_back(c);
    end
    for (k = n - 1; k >= 0; k--) begin
      c.code = CHAR_ZERO + 8'(digits[k]);
      c.last = (k == 0);
      pending_chars.push_back(c);
    end
    if (n + (neg ? 1 : 0) == NUM_DIGITS) full_width_words++;
  endfunction

  // typed-in expectation for directed rows
  function automatic void push_text(input string txt);
    ascii_char_t c;
    int          i;
    for (i = 0; i < txt.len(); i++) begin
      c.code = txt[i];
      c.last = (i == txt.len() - 1);
      pending_chars.push_back(c);
    end
    if (txt.len() == NUM_DIGITS) full_width_words++;
  endfunction

  // directed table: empty txt means "ask the formatter"
  function automatic void directed_row(input int idx, output logic [63:0] v,
                                       output logic sm, output string txt);
    txt = "";
    v   = 64'd0;
    sm  = MODE_UNSIGNED;
    case (idx)
      0:  begin v = 64'd0;                    sm = MODE_UNSIGNED; txt = "0"; end
      1:  begin v = 64'd0;                    sm = MODE_SIGNED;   txt = "0"; end
      2:  begin v = 64'hFFFF_FFFF_FFFF_FFFF;  sm = MODE_UNSIGNED;
                txt = "18446744073709551615"; end
      3:  begin v = 64'hFFFF_FFFF_FFFF_FFFF;  sm = MODE_SIGNED;   txt = "-1"; end
      4:  begin v = 64'h8000_0000_0000_0000;  sm = MODE_SIGNED;
                txt = "-9223372036854775808"; end
      5:  begin v = 64'h8000_0000_0000_0000;  sm = MODE_UNSIGNED;
                txt = "9223372036854775808"; end
      6:  begin v = 64'h7FFF_FFFF_FFFF_FFFF;  sm = MODE_SIGNED;
                txt = "9223372036854775807"; end
      7:  begin v = 64'h7FFF_FFFF_FFFF_FFFF;  sm = MODE_UNSIGNED;
                txt = "9223372036854775807"; end
      8:  begin v = 64'd1;                    sm = MODE_UNSIGNED; txt = "1"; end
      9:  begin v = 64'd9;                    sm = MODE_SIGNED;   txt = "9"; end
      10: begin v = 64'd10;                   sm = MODE_UNSIGNED; txt = "10"; end
      11: begin v = 64'hFFFF_FFFF_FFFF_FFFE;  sm = MODE_SIGNED;   txt = "-2"; end
      12: begin v = 64'd10000000000000000000; sm = MODE_UNSIGNED;
                txt = "10000000000000000000"; end
      13: begin v = 64'd9999999999999999999;  sm = MODE_UNSIGNED;
                txt = "9999999999999999999"; end
      14: begin v = -64'sd10;                 sm = MODE_SIGNED;   end
      15: begin v = 64'd12345678901234567890; sm = MODE_UNSIGNED; end
      16: begin v = 64'h5555_5555_5555_5555;  sm = MODE_SIGNED;   end
      17: begin v = 64'hAAAA_AAAA_AAAA_AAAA;  sm = MODE_SIGNED;   end
      18: begin v = 64'hAAAA_AAAA_AAAA_AAAA;  sm = MODE_UNSIGNED; end
      19: begin v = 64'd99;                   sm = MODE_UNSIGNED; end
      default: begin v = 64'd100;             sm = MODE_SIGNED;   end
    endcase
  endfunction

  // random word: wide, short, near powers of ten, small negatives, extremes
  function automatic void random_word(output logic [63:0] v, output logic sm);
    logic [63:0] mask;
    int          kind;
    kind = $urandom_range(0, 9);
    sm   = 1'($urandom_range(0, 1));
    mask = {64{1'b1}} >> $urandom_range(0, 63);
    case (kind)
      0, 1, 2: v = {$urandom, $urandom};
      3:       v = 64'($urandom_range(0, 999));
      4:       v = {$urandom, $urandom} & mask;
      5:       v = pow10[$urandom_range(0, 19)] + 64'($urandom_range(0, 2)) - 64'd1;
      6: begin
        v  = -64'($urandom_range(0, 1000));
        sm = MODE_SIGNED;
      end
      7: begin
        case ($urandom_range(0, 3))
          0:       v = 64'd0;
          1:       v = 64'hFFFF_FFFF_FFFF_FFFF;
          2:       v = 64'h8000_0000_0000_0000;
          default: v = 64'h7FFF_FFFF_FFFF_FFFF;
        endcase
      end
      default: v = ~({$urandom, $urandom} & mask);
    endcase
  endfunction

  // one word on the input channel; expectations are queued at acceptance
  task automatic send_word(input logic [63:0] v, input logic sm, input string txt);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_value       <= v;
    in_signed_mode <= sm;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (txt.len() != 0) push_text(txt);
    else predict_text(v, sm);
    words_sent++;
    if (sm == MODE_SIGNED && v[63]) negatives_sent++;
  endtask

  // stimulus and end of run
  initial begin
    logic [63:0] v;
    logic        sm;
    string       txt;
    int          i;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_value       <= '0;
    in_signed_mode <= MODE_UNSIGNED;
    steady           = 1'b0;
    mismatches       = 0;
    words_sent       = 0;
    negatives_sent   = 0;
    full_width_words = 0;
    chars_checked    = 0;
    pow10[0] = 64'd1;
    for (i = 1; i < 20; i++) pow10[i] = pow10[i-1] * 64'd10;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_DIRECTED; i++) begin
      directed_row(i, v, sm, txt);
      send_word(v, sm, txt);
    end

    for (i = 0; i < N_RANDOM; i++) begin
      // every third block of 60 words runs with no idling on either side
      steady = ((i / 60) % 3 == 2);
      random_word(v, sm);
      send_word(v, sm, "");
    end
    in_valid <= 1'b0;
    steady = 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d words (%0d negative, %0d of full 20-character width)",
             words_sent, negatives_sent, full_width_words);
    $display("Checked %0d characters, %0d mismatches", chars_checked, mismatches);
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // result channel: random back-pressure, compare each word with the oldest entry
  initial begin
    int          stall;
    ascii_char_t want;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      chars_checked++;
      if (pending_chars.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected char: expected none, got code %0d last %0b",
                 $time, out_char_code, out_last_char);
      end else begin
        want = pending_chars.pop_front();
        if (out_char_code !== want.code) begin
          mismatches++;
          $display("%0t: char_code mismatch: expected %0d, got %0d",
                   $time, want.code, out_char_code);
        end
        if (out_last_char !== want.last) begin
          mismatches++;
          $display("%0t: last_char mismatch: expected %0b, got %0b",
                   $time, want.last, out_last_char);
        end
      end
    end
  end

  // watchdog: too long without any word moving on either channel
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d chars outstanding",
               $time, idle_cycles, pending_chars.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/bda_pkg.sv
hdl/bda_ctrl.sv
hdl/bda_datapath.sv
hdl/binary_to_decimal_ascii_top.sv
tb/sv/tb_binary_to_decimal_ascii_top.sv
